FILE: sv/sorted_table_insert_search_macros.svh
// Assertion helpers shared by the checking code of the sorted table block.
// Each macro samples on the rising edge of clk and is switched off while
// rst_n is low.
`ifndef SORTED_TABLE_INSERT_SEARCH_MACROS_SVH
`define SORTED_TABLE_INSERT_SEARCH_MACROS_SVH

// A property that must hold at every sampled clock edge.
`define STS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen at a sampled clock edge.
`define STS_FORBID(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/stsrch_pkg.sv
package stsrch_pkg;

    // Table geometry and field widths.
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int KEY_W       = 32;
    localparam int INDEX_W     = 8;
    localparam int POS_W       = 9;

    // Register port.
    localparam int PDATA_W     = 32;
    localparam int PADDR_W     = 3;
    localparam logic REG_ENTRY_COUNT = 1'b0;

    // Request kinds.
    typedef enum logic {
        REQ_WRITE  = 1'b0,
        REQ_SEARCH = 1'b1
    } req_t;

    // Search sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // Write port and both read addresses of the key memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } mem_req_t;

    // One search answer.
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } result_t;

endpackage

FILE: sv/sorted_table_insert_search.sv
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+-----------------------------------------
// request  | in        | in_valid / in_stall | req_type, entry_index, entry_key, search_key
// result   | out       | out_valid/out_stall | position, found
// register | in/out    | APB psel/penable    | entry_count at byte address 0
//
// A write request produces no result.
// A search request fetches the first and last entries as it is taken, then
// halves the range once per step in ST_SEARCH, each step waiting on the
// registered read of the key memory; an empty table goes straight to ST_DONE.
// rst_n clears entry_count and the sequencer; the key table is not cleared.
// The next request is accepted while a finished result waits in the output
// register; a search that ends while that register is full waits for it.

module sorted_table_insert_search (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [stsrch_pkg::INDEX_W-1:0]    entry_index,
    input  logic [stsrch_pkg::KEY_W-1:0]      entry_key,
    input  logic [stsrch_pkg::KEY_W-1:0]      search_key,
    // Result channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [stsrch_pkg::POS_W-1:0]      position,
    output logic                              found,
    // Register port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stsrch_pkg::PADDR_W-1:0]    paddr,
    input  logic [stsrch_pkg::PDATA_W-1:0]    pwdata,
    output logic [stsrch_pkg::PDATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int CNT_W   = stsrch_pkg::CNT_W;
    localparam int PDATA_W = stsrch_pkg::PDATA_W;

    logic [CNT_W-1:0]           entry_count_reg, entry_count_next;
    logic                       out_valid_reg, out_valid_next;
    stsrch_pkg::result_t        out_res_reg, out_res_next;

    logic                       reg_write;
    logic                       reg_hit;
    stsrch_pkg::mem_req_t       mem_req;
    logic [stsrch_pkg::KEY_W-1:0] rdata_a;
    logic [stsrch_pkg::KEY_W-1:0] rdata_b;
    logic                       res_valid;
    stsrch_pkg::result_t        res;
    logic                       res_take;

    // Register port: single register, always ready.
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[2] == stsrch_pkg::REG_ENTRY_COUNT);
    assign reg_write = psel && penable && pwrite && pready;
    assign prdata    = reg_hit ? PDATA_W'(entry_count_reg) : '0;

    always_comb
    begin
        entry_count_next = entry_count_reg;
        if (reg_write && reg_hit)
        begin
            entry_count_next = pwdata[CNT_W-1:0];
        end
    end

    // Search sequencer.
    stsrch_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .entry_index (entry_index),
        .entry_key   (entry_key),
        .search_key  (search_key),
        .entry_count (entry_count_reg),
        .mem_req     (mem_req),
        .rdata_a     (rdata_a),
        .rdata_b     (rdata_b),
        .res_valid   (res_valid),
        .res         (res),
        .res_take    (res_take)
    );

    // Key table.
    stsrch_ram #(
        .DEPTH (stsrch_pkg::TABLE_DEPTH),
        .WIDTH (stsrch_pkg::KEY_W)
    ) u_ram (
        .clk     (clk),
        .we      (mem_req.we),
        .waddr   (mem_req.waddr),
        .wdata   (mem_req.wdata),
        .raddr_a (mem_req.raddr_a),
        .raddr_b (mem_req.raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_res_next   = out_res_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = out_res_reg.position;
    assign found     = out_res_reg.found;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

endmodule

FILE: sv/stsrch_ram.sv
module stsrch_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: sv/stsrch_ctrl.sv
`include "sorted_table_insert_search_macros.svh"

module stsrch_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [stsrch_pkg::INDEX_W-1:0] entry_index,
    input  logic [stsrch_pkg::KEY_W-1:0]  entry_key,
    input  logic [stsrch_pkg::KEY_W-1:0]  search_key,
    input  logic [stsrch_pkg::CNT_W-1:0]  entry_count,
    output stsrch_pkg::mem_req_t          mem_req,
    input  logic [stsrch_pkg::KEY_W-1:0]  rdata_a,
    input  logic [stsrch_pkg::KEY_W-1:0]  rdata_b,
    output logic                          res_valid,
    output stsrch_pkg::result_t           res,
    input  logic                          res_take
);

    localparam int ADDR_W = stsrch_pkg::ADDR_W;
    localparam int CNT_W  = stsrch_pkg::CNT_W;
    localparam int KEY_W  = stsrch_pkg::KEY_W;
    localparam int POS_W  = stsrch_pkg::POS_W;

    stsrch_pkg::state_t  state_reg, state_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [KEY_W-1:0]    first_key_reg, first_key_next;
    logic [KEY_W-1:0]    last_key_reg, last_key_next;
    logic                new_last_reg, new_last_next;
    stsrch_pkg::result_t res_reg, res_next;

    logic             accept;
    logic             is_search;
    logic [CNT_W-1:0] count_clamped;
    logic [KEY_W-1:0] last_k;
    logic [CNT_W-1:0] base_ext;
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] upper_base;
    logic [CNT_W-1:0] upper_n;
    logic [CNT_W-1:0] lower_last;
    logic [CNT_W-1:0] lower_mid;
    logic [CNT_W-1:0] upper_mid;
    logic [CNT_W-1:0] idle_last;
    logic             go_lower;
    logic             search_done;
    logic [CNT_W-1:0] done_pos;
    logic             done_found;

    // Handshake and request decode.
    assign in_stall  = (state_reg != stsrch_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign is_search = (req_type == stsrch_pkg::REQ_SEARCH);

    // Counts above the table depth search the whole table.
    assign count_clamped = (entry_count > CNT_W'(stsrch_pkg::TABLE_DEPTH)) ?
                           CNT_W'(stsrch_pkg::TABLE_DEPTH) : entry_count;
    assign idle_last     = count_clamped - CNT_W'(1);

    // Range arithmetic for the current step. The last key comes straight
    // from the read port when it was fetched for this step.
    assign last_k     = new_last_reg ? rdata_a : last_key_reg;
    assign base_ext   = {1'b0, base_reg};
    assign half       = n_reg >> 1;
    assign upper_base = base_ext + half;
    assign upper_n    = n_reg - half;
    assign lower_last = base_ext + half - CNT_W'(1);
    assign lower_mid  = base_ext + (half >> 1);
    assign upper_mid  = upper_base + (upper_n >> 1);
    assign go_lower   = (key_reg < rdata_b);

    // End tests of the current range, in the order the search makes them.
    always_comb
    begin
        search_done = 1'b1;
        done_pos    = base_ext;
        done_found  = 1'b0;
        if (key_reg <= first_key_reg)
        begin
            done_pos   = base_ext;
            done_found = (key_reg == first_key_reg);
        end
        else if (n_reg == CNT_W'(1))
        begin
            done_pos = base_ext + CNT_W'(1);
        end
        else if (key_reg > last_k)
        begin
            done_pos = base_ext + n_reg;
        end
        else if (key_reg == last_k)
        begin
            done_pos   = base_ext + n_reg - CNT_W'(1);
            done_found = 1'b1;
        end
        else if (n_reg == CNT_W'(2))
        begin
            done_pos = base_ext + CNT_W'(1);
        end
        else
        begin
            search_done = 1'b0;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stsrch_pkg::ST_IDLE:
            begin
                if (accept && is_search)
                begin
                    state_next = (count_clamped == '0) ? stsrch_pkg::ST_DONE
                                                       : stsrch_pkg::ST_LOAD;
                end
            end
            stsrch_pkg::ST_LOAD:
            begin
                state_next = stsrch_pkg::ST_SEARCH;
            end
            stsrch_pkg::ST_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = stsrch_pkg::ST_DONE;
                end
            end
            stsrch_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = stsrch_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stsrch_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath updates and memory requests for each state.
    always_comb
    begin
        key_next       = key_reg;
        base_next      = base_reg;
        n_next         = n_reg;
        first_key_next = first_key_reg;
        last_key_next  = last_key_reg;
        new_last_next  = new_last_reg;
        res_next       = res_reg;

        mem_req.we      = accept && !is_search;
        mem_req.waddr   = entry_index[ADDR_W-1:0];
        mem_req.wdata   = entry_key;
        mem_req.raddr_a = idle_last[ADDR_W-1:0];
        mem_req.raddr_b = '0;

        case (state_reg)
            stsrch_pkg::ST_IDLE:
            begin
                // Fetch the first and last entries as the search is taken.
                if (accept && is_search)
                begin
                    key_next      = search_key;
                    base_next     = '0;
                    n_next        = count_clamped;
                    new_last_next = 1'b0;
                    res_next      = '{position: '0, found: 1'b0};
                end
            end
            stsrch_pkg::ST_LOAD:
            begin
                // Latch both ends and fetch the middle entry.
                first_key_next  = rdata_b;
                last_key_next   = rdata_a;
                new_last_next   = 1'b0;
                mem_req.raddr_b = half[ADDR_W-1:0];
            end
            stsrch_pkg::ST_SEARCH:
            begin
                if (search_done)
                begin
                    res_next = '{position: done_pos[POS_W-1:0], found: done_found};
                end
                else
                begin
                    last_key_next = last_k;
                    if (go_lower)
                    begin
                        // Lower half keeps its first entry; fetch the new last one.
                        n_next          = half;
                        new_last_next   = 1'b1;
                        mem_req.raddr_a = lower_last[ADDR_W-1:0];
                        mem_req.raddr_b = lower_mid[ADDR_W-1:0];
                    end
                    else
                    begin
                        // Upper half starts at the middle entry just read.
                        base_next       = upper_base[ADDR_W-1:0];
                        n_next          = upper_n;
                        first_key_next  = rdata_b;
                        new_last_next   = 1'b0;
                        mem_req.raddr_b = upper_mid[ADDR_W-1:0];
                    end
                end
            end
            stsrch_pkg::ST_DONE:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    assign res_valid = (state_reg == stsrch_pkg::ST_DONE);
    assign res       = res_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stsrch_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Search datapath registers.
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        base_reg      <= base_next;
        n_reg         <= n_next;
        first_key_reg <= first_key_next;
        last_key_reg  <= last_key_next;
        new_last_reg  <= new_last_next;
        res_reg       <= res_next;
    end

    // Checks on the search sequencer.
    `STS_ASSERT(a_range_in_table,
        (state_reg == stsrch_pkg::ST_SEARCH) |->
        (n_reg != '0) && (base_ext + n_reg <= CNT_W'(stsrch_pkg::TABLE_DEPTH)),
        "search range is empty or runs past the table")
    `STS_ASSERT(a_range_shrinks,
        (state_reg == stsrch_pkg::ST_SEARCH) &&
        $past(state_reg == stsrch_pkg::ST_SEARCH) |-> (n_reg < $past(n_reg)),
        "search range did not shrink between steps")
    `STS_ASSERT(a_search_starts,
        (accept && is_search) |=>
        (state_reg == stsrch_pkg::ST_LOAD) || (state_reg == stsrch_pkg::ST_DONE),
        "accepted search did not start")
    `STS_ASSERT(a_result_held,
        (state_reg == stsrch_pkg::ST_DONE) && !res_take |=>
        (state_reg == stsrch_pkg::ST_DONE) && $stable(res_reg),
        "pending result changed before it was taken")
    `STS_FORBID(a_no_write_in_search,
        mem_req.we && (state_reg != stsrch_pkg::ST_IDLE),
        "table written while a search is running")

endmodule
